// ===== hdl/qpt_pkg.sv =====
// Package for the quaternion point transform: field widths, register map and
// the stage-enable bundle shared by the pipeline modules. No dependencies.
package qpt_pkg;

    localparam int PT_W     = 24;           // Q12.12 coordinates and translation
    localparam int Q_W      = 16;           // Q2.14 quaternion, Q8.8 scale
    localparam int ADDR_W   = 5;            // eight 32-bit registers
    localparam int DATA_W   = 32;
    localparam int NSTAGE   = 7;            // register stages from input to output

    // Intermediate widths, sized for the worst case of every operand.
    localparam int SQ_W     = 2 * Q_W;      // w*w and friends
    localparam int PR_W     = Q_W + PT_W;   // 16 x 24 products
    localparam int S2_W     = SQ_W + 2;     // w*w - (x*x + y*y + z*z)
    localparam int D_W      = PR_W + 2;     // dot product of v and p
    localparam int C_W      = PR_W + 1;     // cross product component
    localparam int SP_W     = S2_W + PT_W;
    localparam int DV_W     = D_W + Q_W;
    localparam int WC_W     = C_W + Q_W;
    localparam int R_W      = SP_W + 3;     // rotated value, 40 fraction bits
    localparam int ROT_FRAC = 28;
    localparam int T_W      = R_W - ROT_FRAC + 2;  // rotated Q12.12 plus translation
    localparam int M_W      = T_W + Q_W;           // times scale, 20 fraction bits
    localparam int SCL_FRAC = 8;

    typedef enum logic [2:0] {
        REG_ROT_W   = 3'd0,
        REG_ROT_X   = 3'd1,
        REG_ROT_Y   = 3'd2,
        REG_ROT_Z   = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_SHIFT_Z = 3'd6,
        REG_SCALE   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [Q_W-1:0]  rot_w;
        logic signed [Q_W-1:0]  rot_x;
        logic signed [Q_W-1:0]  rot_y;
        logic signed [Q_W-1:0]  rot_z;
        logic signed [PT_W-1:0] shift_x;
        logic signed [PT_W-1:0] shift_y;
        logic signed [PT_W-1:0] shift_z;
        logic signed [Q_W-1:0]  scale;
    } t_cfg;

    // Per-stage load enables, index 0 is the stage nearest the input.
    typedef struct packed {
        logic [NSTAGE-1:0] ce;
    } t_flow;

    typedef logic signed [PT_W-1:0] t_coord;
    typedef logic signed [R_W-1:0]  t_rot;

endpackage

// ===== hdl/qpt_regs.sv =====
// Configuration register file behind an APB-style port.
// Depends on qpt_pkg for the register map and the configuration struct.
module qpt_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [qpt_pkg::ADDR_W-1:0] paddr,
    input  logic [qpt_pkg::DATA_W-1:0] pwdata,
    output logic [qpt_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output qpt_pkg::t_cfg              o_cfg
);
    import qpt_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot_w   <= Q_W'(16384);
            r_cfg.rot_x   <= '0;
            r_cfg.rot_y   <= '0;
            r_cfg.rot_z   <= '0;
            r_cfg.shift_x <= '0;
            r_cfg.shift_y <= '0;
            r_cfg.shift_z <= '0;
            r_cfg.scale   <= Q_W'(256);
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_ROT_W:   r_cfg.rot_w   <= pwdata[Q_W-1:0];
                REG_ROT_X:   r_cfg.rot_x   <= pwdata[Q_W-1:0];
                REG_ROT_Y:   r_cfg.rot_y   <= pwdata[Q_W-1:0];
                REG_ROT_Z:   r_cfg.rot_z   <= pwdata[Q_W-1:0];
                REG_SHIFT_X: r_cfg.shift_x <= pwdata[PT_W-1:0];
                REG_SHIFT_Y: r_cfg.shift_y <= pwdata[PT_W-1:0];
                REG_SHIFT_Z: r_cfg.shift_z <= pwdata[PT_W-1:0];
                REG_SCALE:   r_cfg.scale   <= pwdata[Q_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ROT_W:   prdata = DATA_W'($unsigned(r_cfg.rot_w));
            REG_ROT_X:   prdata = DATA_W'($unsigned(r_cfg.rot_x));
            REG_ROT_Y:   prdata = DATA_W'($unsigned(r_cfg.rot_y));
            REG_ROT_Z:   prdata = DATA_W'($unsigned(r_cfg.rot_z));
            REG_SHIFT_X: prdata = DATA_W'($unsigned(r_cfg.shift_x));
            REG_SHIFT_Y: prdata = DATA_W'($unsigned(r_cfg.shift_y));
            REG_SHIFT_Z: prdata = DATA_W'($unsigned(r_cfg.shift_z));
            REG_SCALE:   prdata = DATA_W'($unsigned(r_cfg.scale));
            default:     prdata = '0;
        endcase
    end

endmodule

// ===== hdl/qpt_flow.sv =====
// Valid bits and load enables of the seven-stage pipeline; a stage loads
// when it is empty or when the stage after it loads. Depends on qpt_pkg.
module qpt_flow (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_m_tready,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    output qpt_pkg::t_flow o_flow
);
    import qpt_pkg::*;

    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] n_vld;
    logic [NSTAGE-1:0] w_ce;

    always_comb begin
        w_ce[NSTAGE-1] = !r_vld[NSTAGE-1] || i_m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            w_ce[k] = !r_vld[k] || w_ce[k+1];
        end
    end

    always_comb begin
        n_vld[0] = w_ce[0] ? i_s_tvalid : r_vld[0];
        for (int k = 1; k < NSTAGE; k++) begin
            n_vld[k] = w_ce[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_flow.ce  = w_ce;
    assign o_s_tready = w_ce[0];
    assign o_m_tvalid = r_vld[NSTAGE-1];

endmodule

// ===== hdl/qpt_rotate.sv =====
// Stages 0 to 3: the sandwich product q*p*conj(q) expanded into
// s2*p + 2*d*v + 2*w*(v x p), kept exact at 40 fraction bits. Uses qpt_pkg.
module qpt_rotate (
    input  logic            i_clk,
    input  qpt_pkg::t_flow  i_flow,
    input  qpt_pkg::t_cfg   i_cfg,
    input  qpt_pkg::t_coord i_p [3],
    input  logic            i_last,
    output qpt_pkg::t_rot   o_r [3],
    output logic            o_last
);
    import qpt_pkg::*;

    // Stage 0: the squares of the quaternion components and every product of its vector part with the point.
    logic signed [SQ_W-1:0] r0_ww, r0_xx, r0_yy, r0_zz;
    logic signed [PR_W-1:0] r0_xpx, r0_ypy, r0_zpz;
    logic signed [PR_W-1:0] r0_ypz, r0_zpy, r0_zpx, r0_xpz, r0_xpy, r0_ypx;
    t_coord                 r0_p [3];
    logic                   r0_last;
    // Stage 1: s2, the dot product and the cross product.
    logic signed [S2_W-1:0] r1_s2;
    logic signed [D_W-1:0]  r1_d;
    logic signed [C_W-1:0]  r1_c [3];
    t_coord                 r1_p [3];
    logic                   r1_last;
    // Stage 2: the three terms of each coordinate.
    logic signed [SP_W-1:0] r2_sp [3];
    logic signed [DV_W-1:0] r2_dv [3];
    logic signed [WC_W-1:0] r2_wc [3];
    logic                   r2_last;
    // Stage 3: their sum.
    t_rot                   r3_r [3];
    logic                   r3_last;

    logic signed [Q_W-1:0]  w_v [3];

    assign w_v[0] = i_cfg.rot_x;
    assign w_v[1] = i_cfg.rot_y;
    assign w_v[2] = i_cfg.rot_z;

    always_ff @(posedge i_clk) begin
        if (i_flow.ce[0]) begin
            r0_ww   <= SQ_W'(i_cfg.rot_w * i_cfg.rot_w);
            r0_xx   <= SQ_W'(i_cfg.rot_x * i_cfg.rot_x);
            r0_yy   <= SQ_W'(i_cfg.rot_y * i_cfg.rot_y);
            r0_zz   <= SQ_W'(i_cfg.rot_z * i_cfg.rot_z);
            r0_xpx  <= PR_W'(i_cfg.rot_x * i_p[0]);
            r0_ypy  <= PR_W'(i_cfg.rot_y * i_p[1]);
            r0_zpz  <= PR_W'(i_cfg.rot_z * i_p[2]);
            r0_ypz  <= PR_W'(i_cfg.rot_y * i_p[2]);
            r0_zpy  <= PR_W'(i_cfg.rot_z * i_p[1]);
            r0_zpx  <= PR_W'(i_cfg.rot_z * i_p[0]);
            r0_xpz  <= PR_W'(i_cfg.rot_x * i_p[2]);
            r0_xpy  <= PR_W'(i_cfg.rot_x * i_p[1]);
            r0_ypx  <= PR_W'(i_cfg.rot_y * i_p[0]);
            r0_p    <= i_p;
            r0_last <= i_last;
        end
        if (i_flow.ce[1]) begin
            r1_s2   <= S2_W'(r0_ww) - (S2_W'(r0_xx) + S2_W'(r0_yy) + S2_W'(r0_zz));
            r1_d    <= D_W'(r0_xpx) + D_W'(r0_ypy) + D_W'(r0_zpz);
            r1_c[0] <= C_W'(r0_ypz) - C_W'(r0_zpy);
            r1_c[1] <= C_W'(r0_zpx) - C_W'(r0_xpz);
            r1_c[2] <= C_W'(r0_xpy) - C_W'(r0_ypx);
            r1_p    <= r0_p;
            r1_last <= r0_last;
        end
        if (i_flow.ce[2]) begin
            for (int i = 0; i < 3; i++) begin
                r2_sp[i] <= SP_W'(r1_s2 * r1_p[i]);
                r2_dv[i] <= DV_W'(r1_d * w_v[i]);
                r2_wc[i] <= WC_W'(i_cfg.rot_w * r1_c[i]);
            end
            r2_last <= r1_last;
        end
        if (i_flow.ce[3]) begin
            for (int i = 0; i < 3; i++) begin
                r3_r[i] <= R_W'(r2_sp[i]) + (R_W'(r2_dv[i]) <<< 1)
                         + (R_W'(r2_wc[i]) <<< 1);
            end
            r3_last <= r2_last;
        end
    end

    assign o_r    = r3_r;
    assign o_last = r3_last;

endmodule

// ===== hdl/qpt_finish.sv =====
// Stages 4 to 6: round the rotation to Q12.12 and add the translation,
// multiply by the scale, round and saturate. Uses qpt_pkg.
module qpt_finish (
    input  logic            i_clk,
    input  qpt_pkg::t_flow  i_flow,
    input  qpt_pkg::t_cfg   i_cfg,
    input  qpt_pkg::t_rot   i_r [3],
    input  logic            i_last,
    output qpt_pkg::t_coord o_q [3],
    output logic            o_clip,
    output logic            o_last
);
    import qpt_pkg::*;

    localparam logic signed [R_W-1:0]  ROT_HALF = R_W'(1) <<< (ROT_FRAC - 1);
    localparam logic signed [M_W-1:0]  SCL_HALF = M_W'(1) <<< (SCL_FRAC - 1);
    localparam logic signed [M_W-1:0]  OUT_MAX  = M_W'((1 << (PT_W - 1)) - 1);
    localparam logic signed [M_W-1:0]  OUT_MIN  = -(M_W'(1) <<< (PT_W - 1));

    logic signed [T_W-1:0] r4_t [3];
    logic                  r4_last;
    logic signed [M_W-1:0] r5_m [3];
    logic                  r5_last;
    t_coord                r6_q [3];
    logic                  r6_clip;
    logic                  r6_last;

    t_coord                w_tr [3];
    logic signed [M_W-1:0] w_rnd [3];
    t_coord                w_sat [3];
    logic [2:0]            w_clip;

    assign w_tr[0] = i_cfg.shift_x;
    assign w_tr[1] = i_cfg.shift_y;
    assign w_tr[2] = i_cfg.shift_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rnd[i] = (r5_m[i] + SCL_HALF) >>> SCL_FRAC;
            if (w_rnd[i] > OUT_MAX) begin
                w_sat[i]  = PT_W'(OUT_MAX);
                w_clip[i] = 1'b1;
            end else if (w_rnd[i] < OUT_MIN) begin
                w_sat[i]  = PT_W'(OUT_MIN);
                w_clip[i] = 1'b1;
            end else begin
                w_sat[i]  = PT_W'(w_rnd[i]);
                w_clip[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.ce[4]) begin
            for (int i = 0; i < 3; i++) begin
                r4_t[i] <= T_W'((i_r[i] + ROT_HALF) >>> ROT_FRAC) + T_W'(w_tr[i]);
            end
            r4_last <= i_last;
        end
        if (i_flow.ce[5]) begin
            for (int i = 0; i < 3; i++) begin
                r5_m[i] <= M_W'(r4_t[i] * i_cfg.scale);
            end
            r5_last <= r4_last;
        end
        if (i_flow.ce[6]) begin
            r6_q    <= w_sat;
            r6_clip <= |w_clip;
            r6_last <= r5_last;
        end
    end

    assign o_q    = r6_q;
    assign o_clip = r6_clip;
    assign o_last = r6_last;

endmodule

// ===== hdl/quaternion_point_transform_top.sv =====
// Top level of the quaternion point transform.
// Depends on qpt_pkg, qpt_regs, qpt_flow, qpt_rotate and qpt_finish.
//
// Usage:
//   Points arrive as beats on the slave stream (i_s_*) and leave as beats on
//   the master stream (o_m_*), one result beat for every input beat, in order.
//   Each point is rotated by the quaternion (w, x, y, z) as q*p*conj(q); a
//   quaternion that is not of unit length also scales by its squared norm.
//   The translation is then added, the sum is multiplied by the scale, and
//   every coordinate saturates to 24 bits, with tuser reporting any clipping.
//   tlast is carried from the input beat to its result beat.
//
//   The eight registers sit on the APB-style port at byte addresses 0x00 to
//   0x1C; write them only while no point is in flight.
//
//   The result beat passes through the seven register stages of the datapath
//   (four for the rotation, three for rounding, scaling and saturation). One
//   beat is accepted per cycle while the receiver takes results.
//   When the receiver stalls, the pipeline keeps filling its empty stages,
//   so input beats are still taken until every stage holds a point; nothing
//   is dropped or repeated. Synchronous reset empties the pipeline and loads
//   identity values into the registers (unit quaternion, zero translation,
//   scale of one).
module quaternion_point_transform_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input stream.
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [71:0]                i_s_tdata,  // point_x, point_y, point_z
    input  logic                       i_s_tlast,  // last_point
    // Output stream.
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [71:0]                o_m_tdata,  // out_x, out_y, out_z
    output logic                       o_m_tuser,  // clipped
    output logic                       o_m_tlast,  // last_out
    // Configuration port.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [qpt_pkg::ADDR_W-1:0] paddr,
    input  logic [qpt_pkg::DATA_W-1:0] pwdata,
    output logic [qpt_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import qpt_pkg::*;

    t_cfg   w_cfg;
    t_flow  w_flow;
    t_coord w_p [3];
    t_rot   w_r [3];
    logic   w_r_last;
    t_coord w_q [3];

    // Unpack the point, x in the lowest bits.
    assign w_p[0] = i_s_tdata[PT_W-1:0];
    assign w_p[1] = i_s_tdata[2*PT_W-1:PT_W];
    assign w_p[2] = i_s_tdata[3*PT_W-1:2*PT_W];

    qpt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Valid bits and per-stage enables for the whole datapath.
    qpt_flow u_flow (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_flow     (w_flow)
    );

    qpt_rotate u_rotate (
        .i_clk  (i_clk),
        .i_flow (w_flow),
        .i_cfg  (w_cfg),
        .i_p    (w_p),
        .i_last (i_s_tlast),
        .o_r    (w_r),
        .o_last (w_r_last)
    );

    qpt_finish u_finish (
        .i_clk  (i_clk),
        .i_flow (w_flow),
        .i_cfg  (w_cfg),
        .i_r    (w_r),
        .i_last (w_r_last),
        .o_q    (w_q),
        .o_clip (o_m_tuser),
        .o_last (o_m_tlast)
    );

    assign o_m_tdata = {w_q[2], w_q[1], w_q[0]};

endmodule

// ===== hdl/qpt_checker.sv =====
// Port-level checks for the quaternion point transform, bound to its top
// level. Depends only on the ports of quaternion_point_transform_top.
module qpt_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [71:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        o_m_tlast
);

    // Nothing is offered in the cycle after reset.
    a_reset_empty : assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_tvalid)
        else $error("result offered right after reset");

    // A stalled result beat holds its payload.
    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // With room at the output the whole pipeline moves, so input is taken.
    a_ready_flow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input stalled although the output can drain");

    // A clipped result has at least one coordinate at a saturation limit.
    a_clip_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            o_m_tdata[23:0] == 24'h7FFFFF || o_m_tdata[23:0] == 24'h800000
            || o_m_tdata[47:24] == 24'h7FFFFF || o_m_tdata[47:24] == 24'h800000
            || o_m_tdata[71:48] == 24'h7FFFFF || o_m_tdata[71:48] == 24'h800000)
        else $error("clip flag without a saturated coordinate");

endmodule

bind quaternion_point_transform_top qpt_port_checks u_qpt_port_checks (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
